// ----- hdl/phase_transition_validator_top_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the phase transition validator
// Shared property forms. Each expects clk and rst in scope.
// ----------------------------------------------------------------------------
`ifndef PHASE_TRANSITION_VALIDATOR_TOP_ASSERT_SVH
`define PHASE_TRANSITION_VALIDATOR_TOP_ASSERT_SVH

// Same-cycle implication
`define PTV_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define PTV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/ptv_pkg.sv -----
// ----------------------------------------------------------------------------
// ptv_pkg
// Types, codes and sizes shared by the phase transition validator.
// ----------------------------------------------------------------------------
package ptv_pkg;

  localparam int MAX_RULES = 16;
  localparam int TAG_BITS  = 16;
  localparam int TICK_BITS = 48;
  localparam int CNT_BITS  = $clog2(MAX_RULES + 1);

  typedef logic [TAG_BITS-1:0]  tag_t;
  typedef logic [TICK_BITS-1:0] tick_t;
  typedef logic [CNT_BITS-1:0]  cnt_t;
  typedef logic [1:0]           code_t;

  // item modes
  localparam code_t MODE_ADD   = 2'd0;
  localparam code_t MODE_ENTER = 2'd1;
  localparam code_t MODE_CHECK = 2'd2;

  // result status
  localparam code_t ST_OK          = 2'd0;
  localparam code_t ST_WRONG_PHASE = 2'd1;
  localparam code_t ST_INVALID     = 2'd2;
  localparam code_t ST_FULL        = 2'd3;

  // event kinds
  localparam code_t EV_NONE  = 2'd0;
  localparam code_t EV_LEAVE = 2'd1;
  localparam code_t EV_ENTER = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECIDE,
    S_SECOND
  } state_t;

  typedef struct packed {
    tag_t from;
    tag_t to;
    logic any;
  } rule_t;

  // controls broadcast along the rule row
  typedef struct packed {
    logic  load;   // latch match flags for a new item
    logic  shift;  // insert fresh rule at the head of the row
    tag_t  q_to;
    tag_t  q_cur;
    rule_t fresh;
  } row_ctl_t;

endpackage

// ----- hdl/ptv_cmd_if.sv -----
// ----------------------------------------------------------------------------
// ptv_cmd_if
// Input item channel: valid/ready handshake with the request fields.
// ----------------------------------------------------------------------------
interface ptv_cmd_if;
  logic          valid;
  logic          ready;
  ptv_pkg::code_t mode;
  ptv_pkg::tag_t  from_phase;
  logic          from_any;
  ptv_pkg::tag_t  to_phase;
  ptv_pkg::tick_t tick;

  modport source (
    output valid, mode, from_phase, from_any, to_phase, tick,
    input  ready
  );
  modport sink (
    input  valid, mode, from_phase, from_any, to_phase, tick,
    output ready
  );
endinterface

// ----- hdl/ptv_rsp_if.sv -----
// ----------------------------------------------------------------------------
// ptv_rsp_if
// Result item channel: valid/ready handshake with the result fields.
// ----------------------------------------------------------------------------
interface ptv_rsp_if;
  logic           valid;
  logic           ready;
  ptv_pkg::code_t status;
  ptv_pkg::code_t event_kind;
  ptv_pkg::tag_t  event_phase;
  ptv_pkg::tick_t event_tick;
  logic           last;

  modport source (
    output valid, status, event_kind, event_phase, event_tick, last,
    input  ready
  );
  modport sink (
    input  valid, status, event_kind, event_phase, event_tick, last,
    output ready
  );
endinterface

// ----- hdl/ptv_cell.sv -----
// ----------------------------------------------------------------------------
// ptv_cell
// One rule slot of the row. Takes its neighbour's rule on insert and
// flags a match against the target of a newly accepted item.
// ----------------------------------------------------------------------------
module ptv_cell (
  input  logic              clk,
  input  ptv_pkg::row_ctl_t ctl,
  input  ptv_pkg::rule_t    prev,
  input  logic              occupied,
  output ptv_pkg::rule_t    rule,
  output logic              hit
);

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      rule <= prev;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      hit <= occupied && (rule.to == ctl.q_to) &&
             (rule.any || (rule.from == ctl.q_cur));
    end
  end

endmodule

// ----- hdl/ptv_ctrl.sv -----
// ----------------------------------------------------------------------------
// ptv_ctrl
// Item sequencer: holds the current phase and rule count, decides each
// item from the row's match flags and drives the result register.
// ----------------------------------------------------------------------------
module ptv_ctrl (
  input  logic                           clk,
  input  logic                           rst,
  ptv_cmd_if.sink                        cmd,
  ptv_rsp_if.source                      rsp,
  input  logic [ptv_pkg::MAX_RULES-1:0]  hits,
  output ptv_pkg::cnt_t                  rule_count,
  output ptv_pkg::row_ctl_t              row_ctl
);

  ptv_pkg::state_t state, state_next;
  ptv_pkg::tag_t   current_phase;

  ptv_pkg::code_t  q_mode;
  ptv_pkg::tag_t   q_from;
  logic            q_any;
  ptv_pkg::tag_t   q_to;
  ptv_pkg::tick_t  q_tick;

  logic            rsp_valid;
  ptv_pkg::code_t  rsp_status;
  ptv_pkg::code_t  rsp_kind;
  ptv_pkg::tag_t   rsp_phase;
  ptv_pkg::tick_t  rsp_tick;
  logic            rsp_last;

  logic            accept;
  logic            out_free;
  logic            allowed;
  logic            table_full;

  logic            push;
  logic            shift;
  logic            phase_upd;
  ptv_pkg::code_t  push_status;
  ptv_pkg::code_t  push_kind;
  ptv_pkg::tag_t   push_phase;
  ptv_pkg::tick_t  push_tick;
  logic            push_last;

  assign cmd.ready  = (state == ptv_pkg::S_IDLE);
  assign accept     = cmd.valid && cmd.ready;
  assign out_free   = !rsp_valid || rsp.ready;
  assign table_full = (rule_count == ptv_pkg::cnt_t'(ptv_pkg::MAX_RULES));
  assign allowed    = (q_to != '0) && (q_to != current_phase) && (|hits);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ptv_pkg::S_IDLE: begin
        if (accept) state_next = ptv_pkg::S_DECIDE;
      end
      ptv_pkg::S_DECIDE: begin
        if (out_free) begin
          if (q_mode == ptv_pkg::MODE_ENTER && allowed && current_phase != '0) begin
            state_next = ptv_pkg::S_SECOND;
          end else begin
            state_next = ptv_pkg::S_IDLE;
          end
        end
      end
      ptv_pkg::S_SECOND: begin
        if (out_free) state_next = ptv_pkg::S_IDLE;
      end
      default: state_next = ptv_pkg::S_IDLE;
    endcase
  end

  // result and update decode
  always_comb begin
    push        = 1'b0;
    shift       = 1'b0;
    phase_upd   = 1'b0;
    push_status = ptv_pkg::ST_OK;
    push_kind   = ptv_pkg::EV_NONE;
    push_phase  = '0;
    push_tick   = '0;
    push_last   = 1'b1;
    case (state)
      ptv_pkg::S_DECIDE: begin
        push = out_free;
        case (q_mode)
          ptv_pkg::MODE_ADD: begin
            if (q_to == '0) begin
              push_status = ptv_pkg::ST_INVALID;
            end else if (table_full) begin
              push_status = ptv_pkg::ST_FULL;
            end else begin
              shift = out_free;
            end
          end
          ptv_pkg::MODE_ENTER: begin
            if (!allowed) begin
              push_status = ptv_pkg::ST_WRONG_PHASE;
            end else begin
              phase_upd = out_free;
              push_tick = q_tick;
              if (current_phase != '0) begin
                push_kind  = ptv_pkg::EV_LEAVE;
                push_phase = current_phase;
                push_last  = 1'b0;
              end else begin
                push_kind  = ptv_pkg::EV_ENTER;
                push_phase = q_to;
              end
            end
          end
          ptv_pkg::MODE_CHECK: begin
            push_status = allowed ? ptv_pkg::ST_OK : ptv_pkg::ST_WRONG_PHASE;
          end
          default: push_status = ptv_pkg::ST_INVALID;
        endcase
      end
      ptv_pkg::S_SECOND: begin
        // entering event after the leaving one; current phase already moved
        push       = out_free;
        push_kind  = ptv_pkg::EV_ENTER;
        push_phase = current_phase;
        push_tick  = q_tick;
      end
      default: push = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ptv_pkg::S_IDLE;
      current_phase <= '0;
      rule_count    <= '0;
      rsp_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (phase_upd) current_phase <= q_to;
      if (shift) rule_count <= rule_count + ptv_pkg::cnt_t'(1);
      if (push) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_mode <= cmd.mode;
      q_from <= cmd.from_phase;
      q_any  <= cmd.from_any;
      q_to   <= cmd.to_phase;
      q_tick <= cmd.tick;
    end
    if (push) begin
      rsp_status <= push_status;
      rsp_kind   <= push_kind;
      rsp_phase  <= push_phase;
      rsp_tick   <= push_tick;
      rsp_last   <= push_last;
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.status      = rsp_status;
  assign rsp.event_kind  = rsp_kind;
  assign rsp.event_phase = rsp_phase;
  assign rsp.event_tick  = rsp_tick;
  assign rsp.last        = rsp_last;

  always_comb begin
    row_ctl            = '0;
    row_ctl.load       = accept;
    row_ctl.shift      = shift;
    row_ctl.q_to       = cmd.to_phase;
    row_ctl.q_cur      = current_phase;
    row_ctl.fresh.from = q_any ? '0 : q_from;
    row_ctl.fresh.to   = q_to;
    row_ctl.fresh.any  = q_any;
  end

`include "phase_transition_validator_top_assert.svh"

  `PTV_ASSERT_NOW(a_count_bound, 1'b1, rule_count <= ptv_pkg::cnt_t'(ptv_pkg::MAX_RULES), "rule count beyond table size")
  `PTV_ASSERT_NEXT(a_accept_decide, accept, state == ptv_pkg::S_DECIDE, "accepted item not decided next")
  `PTV_ASSERT_NOW(a_leave_not_last, rsp_valid && rsp_kind == ptv_pkg::EV_LEAVE, !rsp_last && state == ptv_pkg::S_SECOND, "leaving event without pending entry")
  `PTV_ASSERT_NOW(a_enter_phase, rsp_valid && rsp_kind == ptv_pkg::EV_ENTER, rsp_phase == current_phase, "entering event disagrees with current phase")

endmodule

// ----- hdl/phase_transition_validator_top.sv -----
// ----------------------------------------------------------------------------
// phase_transition_validator_top
// Programmable phase state machine with a shift-in table of allowed moves.
// ----------------------------------------------------------------------------
// Add items insert a rule at the head of a row of MAX_RULES cells; check and
// enter items are matched against every stored rule at once, each cell
// flagging its own hit when the item is taken. An item is taken, then decided
// from the OR of the registered cell flags once the output register is free,
// and an accepted enter from a current phase yields a leaving event, then an
// entering event. Results sit in an output register, so the next item is
// taken while the last result waits. Tag 0 is "no phase"; after reset there
// is no current phase and the table is empty.
module phase_transition_validator_top (
  input logic       clk,
  input logic       rst,
  ptv_cmd_if.sink   cmd,
  ptv_rsp_if.source rsp
);

  ptv_pkg::row_ctl_t              row_ctl;
  ptv_pkg::cnt_t                  rule_count;
  ptv_pkg::rule_t                 rules [ptv_pkg::MAX_RULES];
  logic [ptv_pkg::MAX_RULES-1:0]  hits;

  ptv_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .rsp        (rsp),
    .hits       (hits),
    .rule_count (rule_count),
    .row_ctl    (row_ctl)
  );

  for (genvar k = 0; k < ptv_pkg::MAX_RULES; k++) begin : g_row
    ptv_pkg::rule_t prev;
    logic           occupied;

    // newest rule lives in cell 0
    if (k == 0) begin : g_head
      assign prev = row_ctl.fresh;
    end else begin : g_body
      assign prev = rules[k-1];
    end
    assign occupied = (rule_count > ptv_pkg::cnt_t'(k));

    ptv_cell u_cell (
      .clk      (clk),
      .ctl      (row_ctl),
      .prev     (prev),
      .occupied (occupied),
      .rule     (rules[k]),
      .hit      (hits[k])
    );
  end

endmodule

// ----- tb/sv/phase_transition_validator_top_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phase_transition_validator_top_test
// Self-checking bench for the phase transition validator. Directed items
// cover the null tag, the from-none source, any-source rules, two-event
// enters and the undefined mode. Random items then walk a small set of
// phases, with some noise. Results are checked against an in-bench model of
// the rule table and current phase.
// ----------------------------------------------------------------------------
module phase_transition_validator_top_test;
  import ptv_pkg::*;

  localparam code_t MODE_UNDEF   = 2'd3;
  localparam int    RANDOM_ITEMS = 1030;
  localparam int    STALL_LIMIT  = 4000;
  localparam int    LONG_HOLD    = 400;

  typedef struct packed {
    code_t mode;
    tag_t  from;
    logic  any;
    tag_t  to;
    tick_t tick;
    logic  drain;  // hold this item back until every result is in
  } command_t;

  typedef struct packed {
    code_t status;
    code_t kind;
    tag_t  phase;
    tick_t tick;
    logic  last;
  } outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ptv_cmd_if cmd_ch ();
  ptv_rsp_if rsp_ch ();

  phase_transition_validator_top dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .rsp (rsp_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // driven copies of the channel inputs, known from time zero
  logic  cmd_valid = 1'b0;
  code_t cmd_mode  = MODE_ADD;
  tag_t  cmd_from  = '0;
  logic  cmd_any   = 1'b0;
  tag_t  cmd_to    = '0;
  tick_t cmd_tick  = '0;
  logic  rsp_ready = 1'b0;

  assign cmd_ch.valid      = cmd_valid;
  assign cmd_ch.mode       = cmd_mode;
  assign cmd_ch.from_phase = cmd_from;
  assign cmd_ch.from_any   = cmd_any;
  assign cmd_ch.to_phase   = cmd_to;
  assign cmd_ch.tick       = cmd_tick;
  assign rsp_ch.ready      = rsp_ready;

  command_t cmd_backlog[$];
  outcome_t due_results[$];
  int       mismatches = 0;

  // model of the phase machine
  tag_t cur_phase = '0;
  tag_t rule_src [MAX_RULES];
  tag_t rule_dst [MAX_RULES];
  logic rule_wild[MAX_RULES];
  int   rule_total = 0;

  function automatic bit move_allowed(tag_t target);
    if (target == '0 || target == cur_phase) return 1'b0;
    for (int i = 0; i < rule_total; i++) begin
      if (rule_dst[i] == target && (rule_wild[i] || rule_src[i] == cur_phase)) begin
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  task automatic expect_result(outcome_t r);
    due_results.insert(due_results.size(), r);
  endtask

  task automatic apply_command(command_t c);
    outcome_t r;
    r = '0;
    r.last = 1'b1;
    case (c.mode)
      MODE_ADD: begin
        if (c.to == '0) begin
          r.status = ST_INVALID;
        end else if (rule_total >= MAX_RULES) begin
          r.status = ST_FULL;
        end else begin
          rule_src[rule_total]  = c.any ? tag_t'(0) : c.from;
          rule_dst[rule_total]  = c.to;
          rule_wild[rule_total] = c.any;
          rule_total++;
          r.status = ST_OK;
        end
        expect_result(r);
      end
      MODE_CHECK: begin
        r.status = move_allowed(c.to) ? ST_OK : ST_WRONG_PHASE;
        expect_result(r);
      end
      MODE_ENTER: begin
        if (!move_allowed(c.to)) begin
          r.status = ST_WRONG_PHASE;
          expect_result(r);
        end else begin
          r.status = ST_OK;
          r.tick   = c.tick;
          if (cur_phase != '0) begin
            r.kind  = EV_LEAVE;
            r.phase = cur_phase;
            r.last  = 1'b0;
            expect_result(r);
          end
          r.kind  = EV_ENTER;
          r.phase = c.to;
          r.last  = 1'b1;
          expect_result(r);
          cur_phase = c.to;
        end
      end
      default: begin
        r.status = ST_INVALID;
        expect_result(r);
      end
    endcase
  endtask

  // stimulus helpers
  task automatic queue_cmd(code_t mode, tag_t from, logic any, tag_t to, tick_t tick);
    command_t c;
    c.mode  = mode;
    c.from  = from;
    c.any   = any;
    c.to    = to;
    c.tick  = tick;
    c.drain = 1'b0;
    cmd_backlog.insert(cmd_backlog.size(), c);
  endtask

  // mostly a small set of phases so that enters often succeed
  function automatic tag_t pick_tag();
    case ($urandom_range(0, 7))
      0:       return 16'h0001;
      1:       return 16'h0002;
      2:       return 16'h0003;
      3:       return 16'h0004;
      4:       return 16'h8000;
      5:       return 16'hFFFF;
      6:       return ($urandom_range(0, 2) == 0) ? tag_t'(0) : 16'h0002;
      default: return tag_t'($urandom);
    endcase
  endfunction

  function automatic command_t random_command();
    command_t c;
    int roll;
    roll = $urandom_range(0, 99);
    c = '0;
    if (roll < 15)      c.mode = MODE_ADD;
    else if (roll < 60) c.mode = MODE_ENTER;
    else if (roll < 93) c.mode = MODE_CHECK;
    else                c.mode = MODE_UNDEF;
    c.from = ($urandom_range(0, 3) == 0) ? tag_t'($urandom) : pick_tag();
    c.any  = ($urandom_range(0, 5) == 0);
    c.to   = pick_tag();
    case ($urandom_range(0, 9))
      0:       c.tick = '0;
      1:       c.tick = '1;
      default: c.tick = tick_t'({$urandom, $urandom});
    endcase
    return c;
  endfunction

  // driver
  int   gap_left = 0;
  logic calm     = 1'b0;  // no idling near the end of the run

  always @(posedge clk) begin : drive_cmd
    logic offer;
    if (rst) begin
      cmd_valid <= 1'b0;
      calm      <= 1'b0;
    end else begin
      offer = cmd_valid;
      if (cmd_valid && cmd_ch.ready) begin
        apply_command(cmd_backlog.pop_front());
        offer = 1'b0;
      end
      if (!offer) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (cmd_backlog.size() != 0) begin
          if (cmd_backlog[0].drain && due_results.size() != 0) begin
            offer = 1'b0;
          end else if (!calm && $urandom_range(0, 5) == 0) begin
            gap_left = $urandom_range(1, 14) - 1;
          end else begin
            offer = 1'b1;
          end
        end
      end
      if (offer) begin
        cmd_mode <= cmd_backlog[0].mode;
        cmd_from <= cmd_backlog[0].from;
        cmd_any  <= cmd_backlog[0].any;
        cmd_to   <= cmd_backlog[0].to;
        cmd_tick <= cmd_backlog[0].tick;
      end
      cmd_valid <= offer;
      calm      <= (cmd_backlog.size() <= 100);
    end
  end

  // monitor and result checks
  int stall_left   = 0;
  int hold_left    = 0;
  int results_seen = 0;
  bit held_once    = 1'b0;

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch_rsp
    outcome_t got;
    outcome_t want;
    logic     next_ready;
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ready) begin
        got.status = rsp_ch.status;
        got.kind   = rsp_ch.event_kind;
        got.phase  = rsp_ch.event_phase;
        got.tick   = rsp_ch.event_tick;
        got.last   = rsp_ch.last;
        if (due_results.size() == 0) begin
          $display("%0t: result with none expected, actual status %0h kind %0h",
                   $time, got.status, got.kind);
          $display("%0t:   phase %0h tick %0h last %0b",
                   $time, got.phase, got.tick, got.last);
          mismatches++;
        end else begin
          want = due_results.pop_front();
          check_field("status", 64'(want.status), 64'(got.status));
          check_field("event_kind", 64'(want.kind), 64'(got.kind));
          check_field("event_phase", 64'(want.phase), 64'(got.phase));
          check_field("event_tick", 64'(want.tick), 64'(got.tick));
          check_field("last", 64'(want.last), 64'(got.last));
        end
        results_seen++;
      end
      // one long hold-off so the block backs up onto its input
      if (hold_left > 0) begin
        hold_left--;
        next_ready = 1'b0;
      end else if (!held_once && results_seen >= 300) begin
        held_once  = 1'b1;
        hold_left  = LONG_HOLD - 1;
        next_ready = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        next_ready = 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 14) - 1;
        next_ready = 1'b0;
      end else begin
        next_ready = 1'b1;
      end
      rsp_ready <= next_ready;
    end
  end

  // watchdog on cycles with no item moving on either side
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (!rst) begin
      if ((cmd_valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("status: fail");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    command_t c;
    queue_cmd(MODE_CHECK, 16'h0000, 1'b0, 16'h0000, 48'h0);         // null target
    queue_cmd(MODE_ENTER, 16'h0000, 1'b0, 16'h0005, 48'h1);         // empty table
    queue_cmd(MODE_UNDEF, 16'hFFFF, 1'b1, 16'hFFFF, '1);
    queue_cmd(MODE_ADD,   16'h0003, 1'b0, 16'h0000, 48'h0);         // null target add
    queue_cmd(MODE_ADD,   16'h0000, 1'b0, 16'h0001, 48'h0);         // from no phase
    queue_cmd(MODE_CHECK, 16'h0000, 1'b0, 16'h0001, 48'h0);
    queue_cmd(MODE_CHECK, 16'h0000, 1'b0, 16'h0002, 48'h0);
    queue_cmd(MODE_ENTER, 16'h0000, 1'b0, 16'h0001, 48'h0);         // single event
    queue_cmd(MODE_ENTER, 16'h0000, 1'b0, 16'h0001, 48'h5);         // already current
    queue_cmd(MODE_ADD,   16'hFFFF, 1'b1, 16'hFFFF, 48'h0);         // any source
    queue_cmd(MODE_ADD,   16'h0000, 1'b0, 16'h0002, 48'h0);
    queue_cmd(MODE_CHECK, 16'h0000, 1'b0, 16'h0002, 48'h0);         // from-none rule, phase held
    queue_cmd(MODE_ENTER, 16'h0000, 1'b0, 16'hFFFF, '1);            // leave then enter
    queue_cmd(MODE_ADD,   16'hFFFF, 1'b0, 16'h0001, 48'h0);
    queue_cmd(MODE_ADD,   16'h0001, 1'b0, 16'h0002, 48'h0);
    queue_cmd(MODE_ENTER, 16'h0000, 1'b0, 16'h0001, 48'hA5A5_5A5A_0F0F);
    queue_cmd(MODE_ENTER, 16'hFFFF, 1'b1, 16'h0002, 48'h5A5A_A5A5_F0F0);
    queue_cmd(MODE_UNDEF, 16'h0000, 1'b0, 16'h0000, 48'h0);
    queue_cmd(MODE_CHECK, 16'h0000, 1'b0, 16'hFFFF, 48'h0);
    queue_cmd(MODE_ENTER, 16'h0000, 1'b0, 16'h0003, 48'h7);
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      c = random_command();
      c.drain = (n == 0 || n == RANDOM_ITEMS / 2);
      cmd_backlog.insert(cmd_backlog.size(), c);
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk); while (cmd_backlog.size() != 0 || due_results.size() != 0);
    repeat (16) @(negedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/ptv_pkg.sv
hdl/ptv_cmd_if.sv
hdl/ptv_rsp_if.sv
hdl/ptv_cell.sv
hdl/ptv_ctrl.sv
hdl/phase_transition_validator_top.sv
tb/sv/phase_transition_validator_top_test.sv
